[sv/mhcc_pkg.sv]
// shared types, constants and helpers for the magic hash collision check
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package mhcc_pkg;

   // result codes
   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_COLLISION = 2'd1;
   localparam logic [1:0] STATUS_TOO_MANY  = 2'd2;

   localparam int WORD_BITS  = 64;
   localparam int HALF_BITS  = 32;
   localparam int POP_BITS   = 7;
   localparam int BYTE_STEPS = 8;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_COUNT,
      ST_CHECK,
      ST_CLEAR,
      ST_STEP,
      ST_MUL_LL,
      ST_MUL_LH,
      ST_MUL_HL,
      ST_SUM,
      ST_READ,
      ST_TEST,
      ST_FINISH
   } state_type;

   typedef enum logic [1:0] {
      MUL_LL,
      MUL_LH,
      MUL_HL
   } mul_sel_type;

   typedef struct packed {
      logic        load;
      logic        count;
      logic        check;
      logic        clear_en;
      logic        step;
      mul_sel_type mul_sel;
      logic        cap_ll;
      logic        cap_cross;
      logic        sum;
      logic        rd_en;
      logic        mark;
   } dp_ctrl_type;

   typedef struct packed {
      logic count_done;
      logic too_many;
      logic empty;
      logic clear_last;
      logic subset_zero;
   } dp_stat_type;

   // set bits in one byte
   function automatic logic [3:0] count8(input logic [7:0] b);
      logic [3:0] n;
      n = 4'd0;
      for (int i = 0; i < 8; i++) begin
         n = n + {3'd0, b[i]};
      end
      return n;
   endfunction

endpackage

`default_nettype wire

[sv/magic_hash_collision_check_top.sv]
// magic multiplier collision check, top level
// depends on mhcc_pkg, mhcc_seen_mem, mhcc_dp and mhcc_ctrl
//
// usage
//  - req channel: one item is an occupancy mask and a candidate multiplier;
//    req_ready is high only while the sequencer is idle
//  - rsp channel: one status per item, 0 collision-free, 1 index collision,
//    2 mask has more than INDEX_BITS set bits
//  - steps per item, with p the popcount of the mask: popcount over the
//    mask (one byte a cycle), a check, clearing the 2^p entries of the used
//    part of the seen map, the first subset step, then per subset three
//    passes through the shared 32x32 multiplier, the sum, the map read and
//    the test, until a collision or the walk returns to the empty subset
//  - too many bits or an empty mask finish after the check
//  - items are taken one at a time, a new one once the sequencer is idle;
//    the shared multiplier and the seen map read set the per-subset cost
//  - the result sits in an output register, so the next item may be taken
//    while the previous status still waits on a stalled receiver; a finished
//    item whose status cannot yet be placed holds the sequencer
//  - reset clears the sequencer and the output valid; the seen map needs no
//    clearing pass after reset, each item clears the entries it can reach
`timescale 1ns / 1ps
`default_nettype none

module magic_hash_collision_check_top
   import mhcc_pkg::*;
#(
   parameter int INDEX_BITS = 12
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic [WORD_BITS-1:0] req_occupancy_mask,
   input  wire logic [WORD_BITS-1:0] req_test_magic,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic [1:0]                rsp_status
);

   dp_ctrl_type           dp_ctrl;
   dp_stat_type           dp_stat;
   logic                  seen_hit;
   logic                  mem_we;
   logic [INDEX_BITS-1:0] mem_waddr;
   logic                  mem_wdata;
   logic                  mem_re;
   logic [INDEX_BITS-1:0] mem_raddr;

   // sequencer and output register
   mhcc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_status (rsp_status),
      .stat       (dp_stat),
      .seen_hit   (seen_hit),
      .ctrl       (dp_ctrl)
   );

   // popcount, subset walk, shared multiplier and index
   mhcc_dp #(
      .INDEX_BITS (INDEX_BITS)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .req_occupancy_mask (req_occupancy_mask),
      .req_test_magic     (req_test_magic),
      .ctrl               (dp_ctrl),
      .stat               (dp_stat),
      .mem_we             (mem_we),
      .mem_waddr          (mem_waddr),
      .mem_wdata          (mem_wdata),
      .mem_re             (mem_re),
      .mem_raddr          (mem_raddr)
   );

   // seen map, 2^INDEX_BITS one-bit entries
   mhcc_seen_mem #(
      .ADDR_BITS (INDEX_BITS)
   ) u_seen (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (seen_hit)
   );

   // once an item is taken the block is busy
   a_busy_after_accept : assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("item accepted but block still ready");

   // a mark always tests data read in the cycle before
   a_mark_after_read : assert property (@(posedge clock) disable iff (reset)
      dp_ctrl.mark |-> $past(dp_ctrl.rd_en))
      else $error("seen map marked without a preceding read");

   // clearing and marking never share the write port
   a_one_writer : assert property (@(posedge clock) disable iff (reset)
      !(dp_ctrl.clear_en && dp_ctrl.mark))
      else $error("clear and mark in the same cycle");

   // only defined result codes leave the block
   a_status_code : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == STATUS_OK || rsp_status == STATUS_COLLISION ||
                     rsp_status == STATUS_TOO_MANY))
      else $error("undefined result code");

endmodule

`default_nettype wire

[sv/mhcc_seen_mem.sv]
// seen map: one-bit memory, one write and one registered read per cycle
// uses mhcc_pkg for nothing beyond house conventions
`timescale 1ns / 1ps
`default_nettype none

module mhcc_seen_mem
   import mhcc_pkg::*;
#(
   parameter int ADDR_BITS = 12
) (
   input  wire logic                 clock,
   input  wire logic                 wr_en,
   input  wire logic [ADDR_BITS-1:0] wr_addr,
   input  wire logic                 wr_data,
   input  wire logic                 rd_en,
   input  wire logic [ADDR_BITS-1:0] rd_addr,
   output logic                      rd_data
);

   localparam int DEPTH = 1 << ADDR_BITS;

   logic mem_ff [DEPTH];
   logic rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[sv/mhcc_dp.sv]
// datapath: popcount, subset walk, shared 32x32 multiplier, index and clear counter
// depends on mhcc_pkg for control and status structs, widths and count8
`timescale 1ns / 1ps
`default_nettype none

module mhcc_dp
   import mhcc_pkg::*;
#(
   parameter int INDEX_BITS = 12
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic [WORD_BITS-1:0]  req_occupancy_mask,
   input  wire logic [WORD_BITS-1:0]  req_test_magic,
   input  wire dp_ctrl_type           ctrl,
   output dp_stat_type                stat,
   output logic                       mem_we,
   output logic [INDEX_BITS-1:0]      mem_waddr,
   output logic                       mem_wdata,
   output logic                       mem_re,
   output logic [INDEX_BITS-1:0]      mem_raddr
);

   logic [WORD_BITS-1:0]  mask_ff, mask_in;
   logic [WORD_BITS-1:0]  magic_ff, magic_in;
   logic [WORD_BITS-1:0]  cnt_mask_ff, cnt_mask_in;
   logic [2:0]            byte_cnt_ff, byte_cnt_in;
   logic [POP_BITS-1:0]   pop_ff, pop_in;
   logic [INDEX_BITS-1:0] limit_ff, limit_in;
   logic [INDEX_BITS-1:0] clear_addr_ff, clear_addr_in;
   logic [WORD_BITS-1:0]  subset_ff, subset_in;
   logic [WORD_BITS-1:0]  mul_ff, mul_in;
   logic [WORD_BITS-1:0]  ll_ff, ll_in;
   logic [HALF_BITS-1:0]  cross_ff, cross_in;
   logic [WORD_BITS-1:0]  prod_ff, prod_in;
   logic [INDEX_BITS-1:0] idx_ff, idx_in;

   logic [HALF_BITS-1:0]  mul_a, mul_b;
   logic [POP_BITS-1:0]   shift_amt;
   logic [WORD_BITS-1:0]  prod_shift;

   // operand select for the shared multiplier
   always_comb begin
      unique case (ctrl.mul_sel)
         MUL_LH: begin
            mul_a = subset_ff[HALF_BITS-1:0];
            mul_b = magic_ff[WORD_BITS-1:HALF_BITS];
         end
         MUL_HL: begin
            mul_a = subset_ff[WORD_BITS-1:HALF_BITS];
            mul_b = magic_ff[HALF_BITS-1:0];
         end
         default: begin
            mul_a = subset_ff[HALF_BITS-1:0];
            mul_b = magic_ff[HALF_BITS-1:0];
         end
      endcase
   end

   assign shift_amt  = 7'(WORD_BITS) - pop_ff;
   assign prod_shift = prod_ff >> shift_amt;

   always_comb begin
      mask_in       = mask_ff;
      magic_in      = magic_ff;
      cnt_mask_in   = cnt_mask_ff;
      byte_cnt_in   = byte_cnt_ff;
      pop_in        = pop_ff;
      limit_in      = limit_ff;
      clear_addr_in = clear_addr_ff;
      subset_in     = subset_ff;
      mul_in        = {{HALF_BITS{1'b0}}, mul_a} * {{HALF_BITS{1'b0}}, mul_b};
      ll_in         = ll_ff;
      cross_in      = cross_ff;
      prod_in       = prod_ff;
      idx_in        = idx_ff;

      if (ctrl.load) begin
         mask_in       = req_occupancy_mask;
         magic_in      = req_test_magic;
         cnt_mask_in   = req_occupancy_mask;
         byte_cnt_in   = 3'd0;
         pop_in        = '0;
         clear_addr_in = '0;
         subset_in     = '0;
      end
      if (ctrl.count) begin
         pop_in      = pop_ff + {3'd0, count8(cnt_mask_ff[7:0])};
         cnt_mask_in = cnt_mask_ff >> 8;
         byte_cnt_in = byte_cnt_ff + 3'd1;
      end
      if (ctrl.check) begin
         // low pop bits set: the span of indexes this item can reach
         limit_in = ~({INDEX_BITS{1'b1}} << pop_ff);
      end
      if (ctrl.clear_en) begin
         clear_addr_in = clear_addr_ff + 1'b1;
      end
      if (ctrl.step) begin
         // carry-rippler step to the next subset
         subset_in = (subset_ff - mask_ff) & mask_ff;
      end
      if (ctrl.cap_ll) begin
         ll_in = mul_ff;
      end
      if (ctrl.cap_cross) begin
         cross_in = mul_ff[HALF_BITS-1:0];
      end
      if (ctrl.sum) begin
         prod_in = {ll_ff[WORD_BITS-1:HALF_BITS] + cross_ff + mul_ff[HALF_BITS-1:0],
                    ll_ff[HALF_BITS-1:0]};
      end
      if (ctrl.rd_en) begin
         idx_in = prod_shift[INDEX_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_cnt_ff   <= 3'd0;
         clear_addr_ff <= '0;
      end else begin
         byte_cnt_ff   <= byte_cnt_in;
         clear_addr_ff <= clear_addr_in;
      end
   end

   always_ff @(posedge clock) begin
      mask_ff     <= mask_in;
      magic_ff    <= magic_in;
      cnt_mask_ff <= cnt_mask_in;
      pop_ff      <= pop_in;
      limit_ff    <= limit_in;
      subset_ff   <= subset_in;
      mul_ff      <= mul_in;
      ll_ff       <= ll_in;
      cross_ff    <= cross_in;
      prod_ff     <= prod_in;
      idx_ff      <= idx_in;
   end

   assign stat.count_done  = (byte_cnt_ff == 3'(BYTE_STEPS - 1));
   assign stat.too_many    = (pop_ff > 7'(INDEX_BITS));
   assign stat.empty       = (pop_ff == '0);
   assign stat.clear_last  = (clear_addr_ff == limit_ff);
   assign stat.subset_zero = (subset_ff == '0);

   assign mem_we    = ctrl.clear_en | ctrl.mark;
   assign mem_waddr = ctrl.clear_en ? clear_addr_ff : idx_ff;
   assign mem_wdata = ctrl.mark;
   assign mem_re    = ctrl.rd_en;
   assign mem_raddr = prod_shift[INDEX_BITS-1:0];

endmodule

`default_nettype wire

[sv/mhcc_ctrl.sv]
// sequencer: handshakes, state machine, result code and output register
// depends on mhcc_pkg for the state enum, structs and result codes
`timescale 1ns / 1ps
`default_nettype none

module mhcc_ctrl
   import mhcc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [1:0]       rsp_status,
   input  wire dp_stat_type stat,
   input  wire logic        seen_hit,
   output dp_ctrl_type      ctrl
);

   state_type  state_ff, state_in;
   logic [1:0] code_ff, code_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [1:0] rsp_status_ff, rsp_status_in;
   logic       deliver;

   // result leaves once the output register is free or being emptied
   assign deliver = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in = state_ff;
      code_in  = code_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_COUNT;
            end
         end
         ST_COUNT: begin
            if (stat.count_done) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (stat.too_many) begin
               code_in  = STATUS_TOO_MANY;
               state_in = ST_FINISH;
            end else if (stat.empty) begin
               code_in  = STATUS_OK;
               state_in = ST_FINISH;
            end else begin
               state_in = ST_CLEAR;
            end
         end
         ST_CLEAR: begin
            if (stat.clear_last) begin
               state_in = ST_STEP;
            end
         end
         ST_STEP:   state_in = ST_MUL_LL;
         ST_MUL_LL: state_in = ST_MUL_LH;
         ST_MUL_LH: state_in = ST_MUL_HL;
         ST_MUL_HL: state_in = ST_SUM;
         ST_SUM:    state_in = ST_READ;
         ST_READ:   state_in = ST_TEST;
         ST_TEST: begin
            if (seen_hit) begin
               code_in  = STATUS_COLLISION;
               state_in = ST_FINISH;
            end else if (stat.subset_zero) begin
               code_in  = STATUS_OK;
               state_in = ST_FINISH;
            end else begin
               state_in = ST_MUL_LL;
            end
         end
         ST_FINISH: begin
            if (deliver) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      ctrl           = '0;
      ctrl.mul_sel   = MUL_LL;
      req_ready      = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            ctrl.load = req_valid;
         end
         ST_COUNT:  ctrl.count    = 1'b1;
         ST_CHECK:  ctrl.check    = 1'b1;
         ST_CLEAR:  ctrl.clear_en = 1'b1;
         ST_STEP:   ctrl.step     = 1'b1;
         ST_MUL_LL: ctrl.mul_sel  = MUL_LL;
         ST_MUL_LH: begin
            ctrl.mul_sel = MUL_LH;
            ctrl.cap_ll  = 1'b1;
         end
         ST_MUL_HL: begin
            ctrl.mul_sel   = MUL_HL;
            ctrl.cap_cross = 1'b1;
         end
         ST_SUM:  ctrl.sum   = 1'b1;
         ST_READ: ctrl.rd_en = 1'b1;
         ST_TEST: begin
            ctrl.mark = !seen_hit;
            ctrl.step = !seen_hit;
         end
         default: ;
      endcase
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (deliver) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = code_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      code_ff       <= code_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;

endmodule

`default_nettype wire
